[rtl/six_step_commutation_pwm_macros.svh]
// assertion macros for the six-step commutation drive
// used by six_step_commutation_pwm.sv, expects clk and arst_n in scope
`ifndef SIX_STEP_COMMUTATION_PWM_MACROS_SVH
`define SIX_STEP_COMMUTATION_PWM_MACROS_SVH
`ifndef SYNTHESIS
// check on every rising clock edge outside reset
`define SSCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every rising clock edge, reset included
`define SSCP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSCP_ASSERT(lbl, prop, msg)
`define SSCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/sscp_pkg.sv]
// shared types, register map and drive tables for the six-step commutation drive
// no dependencies
`timescale 1ns / 1ps
package sscp_pkg;

	localparam int DutyW  = 16;
	localparam int StateW = 4;
	localparam int PhaseW = 3;
	localparam int AddrW  = 4;
	localparam int DataW  = 32;

	// register indexes, paddr[3:2]
	localparam logic [1:0] REG_DUTY_UPPER   = 2'd0;
	localparam logic [1:0] REG_DUTY_LOWER   = 2'd1;
	localparam logic [1:0] REG_TIMER_PERIOD = 2'd2;

	localparam logic [DutyW-1:0] DUTY_UPPER_RST   = 16'd58982;
	localparam logic [DutyW-1:0] DUTY_LOWER_RST   = 16'd6553;
	localparam logic [DutyW-1:0] TIMER_PERIOD_RST = 16'd2000;

	localparam logic [PhaseW-1:0] STATE_LOCK = 3'd6;
	localparam logic [PhaseW-1:0] STATE_FREE = 3'd7;

	typedef struct packed {
		logic [DutyW-1:0] duty_upper;
		logic [DutyW-1:0] duty_lower;
		logic [DutyW-1:0] timer_period;
	} cfg_t;

	typedef struct packed {
		logic [PhaseW-1:0] high_pwm;
		logic [PhaseW-1:0] low_on;
		logic [PhaseW-1:0] fwd;
		logic [PhaseW-1:0] rev;
	} drive_t;

	// bit0 A, bit1 B, bit2 C
	function automatic drive_t drive_lookup(input logic [StateW-1:0] st);
		drive_t d;
		logic [PhaseW-1:0] idx;
		idx = (st > StateW'(STATE_LOCK)) ? STATE_FREE : st[PhaseW-1:0];
		unique case (idx)
			3'd0: d = '{3'b001, 3'b010, 3'd1, 3'd5};
			3'd1: d = '{3'b001, 3'b100, 3'd2, 3'd0};
			3'd2: d = '{3'b010, 3'b100, 3'd3, 3'd1};
			3'd3: d = '{3'b010, 3'b001, 3'd4, 3'd2};
			3'd4: d = '{3'b100, 3'b001, 3'd5, 3'd3};
			3'd5: d = '{3'b100, 3'b010, 3'd0, 3'd4};
			3'd6: d = '{3'b000, 3'b111, STATE_FREE, STATE_FREE};
			default: d = '{3'b000, 3'b000, STATE_FREE, STATE_FREE};
		endcase
		return d;
	endfunction

endpackage

[rtl/sscp_regs.sv]
// apb register block: duty clamp window and pwm period
// depends on sscp_pkg
`timescale 1ns / 1ps
module sscp_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sscp_pkg::AddrW-1:0] paddr,
	input  logic [sscp_pkg::DataW-1:0] pwdata,
	output logic [sscp_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output sscp_pkg::cfg_t            cfg
);

	sscp_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_upper   <= sscp_pkg::DUTY_UPPER_RST;
			cfg_q.duty_lower   <= sscp_pkg::DUTY_LOWER_RST;
			cfg_q.timer_period <= sscp_pkg::TIMER_PERIOD_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				sscp_pkg::REG_DUTY_UPPER: cfg_q.duty_upper <= pwdata[sscp_pkg::DutyW-1:0];
				sscp_pkg::REG_DUTY_LOWER: cfg_q.duty_lower <= pwdata[sscp_pkg::DutyW-1:0];
				sscp_pkg::REG_TIMER_PERIOD: cfg_q.timer_period <= pwdata[sscp_pkg::DutyW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			sscp_pkg::REG_DUTY_UPPER: prdata = sscp_pkg::DataW'(cfg_q.duty_upper);
			sscp_pkg::REG_DUTY_LOWER: prdata = sscp_pkg::DataW'(cfg_q.duty_lower);
			sscp_pkg::REG_TIMER_PERIOD: prdata = sscp_pkg::DataW'(cfg_q.timer_period);
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[rtl/six_step_commutation_pwm.sv]
// six-step commutation drive: clamp, compare scaling and bridge pattern lookup
// depends on sscp_pkg, sscp_regs and six_step_commutation_pwm_macros.svh
//
// channel   dir  handshake                    beat
// item      in   item_valid / item_ready      phase_state, duty_request
// result    out  result_valid / result_ready  masks, compare_value, applied_*, successors
// apb       in   psel / penable / pready      paddr, pwdata, prdata
//
// one beat per cycle while result_ready is high; items pass the stages below in order
// stages: input register, duty clamp, 16x16 multiply with pattern lookup
// each stage moves when the stage after it is empty or moving, so a stall holds all data
// reset clears the stage valid bits and loads the default clamp window and period
`timescale 1ns / 1ps
`include "six_step_commutation_pwm_macros.svh"
module six_step_commutation_pwm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sscp_pkg::AddrW-1:0]  paddr,
	input  logic [sscp_pkg::DataW-1:0]  pwdata,
	output logic [sscp_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [sscp_pkg::StateW-1:0] phase_state,
	input  logic [sscp_pkg::DutyW-1:0]  duty_request,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [sscp_pkg::PhaseW-1:0] high_pwm_mask,
	output logic [sscp_pkg::PhaseW-1:0] low_on_mask,
	output logic [sscp_pkg::DutyW-1:0]  compare_value,
	output logic [sscp_pkg::DutyW-1:0]  applied_duty,
	output logic [sscp_pkg::StateW-1:0] applied_state,
	output logic [sscp_pkg::PhaseW-1:0] forward_state,
	output logic [sscp_pkg::PhaseW-1:0] reverse_state
);

	sscp_pkg::cfg_t cfg;

	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;

	logic [sscp_pkg::StateW-1:0]  state_s1, state_s2, state_s3;
	logic [sscp_pkg::DutyW-1:0]   req_s1;
	logic [sscp_pkg::DutyW-1:0]   duty_s2, duty_s3;
	logic [2*sscp_pkg::DutyW-1:0] prod_s3;
	sscp_pkg::drive_t             drive_s3;
	logic [sscp_pkg::DutyW-1:0]   duty_clamped;

	sscp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign en_s3      = !valid_s3 || result_ready;
	assign en_s2      = !valid_s2 || en_s3;
	assign en_s1      = !valid_s1 || en_s2;
	assign item_ready = en_s1;

	// upper bound checked first so an inverted window still resolves
	always_comb begin
		priority if (req_s1 > cfg.duty_upper) begin
			duty_clamped = cfg.duty_upper;
		end else if (req_s1 < cfg.duty_lower) begin
			duty_clamped = cfg.duty_lower;
		end else begin
			duty_clamped = req_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= item_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			state_s1 <= phase_state;
			req_s1   <= duty_request;
		end
		if (en_s2) begin
			state_s2 <= state_s1;
			duty_s2  <= duty_clamped;
		end
		if (en_s3) begin
			state_s3 <= state_s2;
			duty_s3  <= duty_s2;
			prod_s3  <= (2*sscp_pkg::DutyW)'(duty_s2) *
				(2*sscp_pkg::DutyW)'(cfg.timer_period);
			drive_s3 <= sscp_pkg::drive_lookup(state_s2);
		end
	end

	assign result_valid  = valid_s3;
	assign high_pwm_mask = drive_s3.high_pwm;
	assign low_on_mask   = drive_s3.low_on;
	assign compare_value = prod_s3[2*sscp_pkg::DutyW-1:sscp_pkg::DutyW];
	assign applied_duty  = duty_s3;
	assign applied_state = state_s3;
	assign forward_state = drive_s3.fwd;
	assign reverse_state = drive_s3.rev;

	// a free output stage never blocks the input
	`SSCP_ASSERT(a_ready_chain, result_ready |-> item_ready, "input stalled with output free")
	// a result only appears from an item held in the clamp stage
	`SSCP_ASSERT(a_result_src, $rose(result_valid) |-> $past(valid_s2), "result from empty stage")
	// never drive high and low of one phase, at most one pwm high side
	`SSCP_ASSERT(a_no_shoot,
		result_valid |-> ($onehot0(high_pwm_mask) && ((high_pwm_mask & low_on_mask) == '0)),
		"shoot-through pattern")
	// lock and free codes have no successor rotation
	`SSCP_ASSERT(a_succ_free,
		(result_valid && (applied_state >= sscp_pkg::StateW'(sscp_pkg::STATE_LOCK))) |->
		((forward_state == sscp_pkg::STATE_FREE) && (reverse_state == sscp_pkg::STATE_FREE)),
		"successor for lock or free")
	// pready is tied high
	`SSCP_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule
